>>> src/modbus_rtu_slave_frame_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU slave frame engine checker.
// Both expect signals named clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_SLAVE_FRAME_ENGINE_ASSERT_SVH
`define MODBUS_RTU_SLAVE_FRAME_ENGINE_ASSERT_SVH

// same-cycle implication
`define MRTU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame engine check failed");

// next-cycle implication
`define MRTU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame engine check failed");

`endif

>>> src/mrtu_pkg.sv
// ----------------------------------------------------------------------------
// mrtu_pkg
// Shared constants and helper functions of the Modbus RTU slave frame engine.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  localparam int COIL_COUNT_DEF     = 512;
  localparam int REG_COUNT_DEF      = 64;
  localparam int RESP_MAX_BYTES_DEF = 64;

  localparam int REQ_LEN       = 8;
  localparam int WIN_DEPTH     = 7;
  localparam int COIL_QTY_MAX  = 2000;
  localparam int HOLD_QTY_MAX  = 8;
  localparam int INPUT_REG_NUM = 4;

  localparam logic [7:0] FC_COILS = 8'h01;
  localparam logic [7:0] FC_HOLD  = 8'h03;
  localparam logic [7:0] FC_INPUT = 8'h04;
  localparam logic [7:0] FC_BCAST = 8'h65;

  localparam logic [1:0]  BOOT_MODE    = 2'd2;
  localparam logic [15:0] NO_ACK       = 16'hFFFF;
  localparam int          MODE_IDX_RST = 0;
  localparam logic [7:0]  SLAVE_RST    = 8'd3;

  localparam logic CFG_SLAVE_ADDR = 1'b0;
  localparam logic CFG_MODE_INDEX = 1'b1;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] input_reg(input logic [1:0] idx);
    logic [15:0] v;
    unique case (idx)
      2'd0: v = 16'h0000;
      2'd1: v = 16'h0000;
      2'd2: v = 16'h0001;
      2'd3: v = 16'h0200;
    endcase
    return v;
  endfunction

endpackage

>>> src/modbus_rtu_slave_frame_engine.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_engine
// Receive window scan, CRC check, request decode and response sequencing.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Content
// in_     | input     | in_valid/in_ready  | rx byte or host mode command
// cfg_    | input     | cfg_valid/ready    | register index and write data
// out_    | output    | out_valid/ready    | response byte or status, plus status
//
// Per item: a mode command reads and updates the coil row and holding register
// (not if ignored); a plain byte is scanned, dropping bytes until an anchor,
// with a CRC pass per full window and a store update per broadcast; a response
// replaces the status load and reads data through each store's single port.
// Reset: synchronous; stores read their reset value through per-row valid bits.
// Stalls: the output register holds a result until taken; a new item is
// accepted once the final result of the last one is loaded.
module modbus_rtu_slave_frame_engine #(
  parameter int COIL_COUNT     = mrtu_pkg::COIL_COUNT_DEF,
  parameter int REG_COUNT      = mrtu_pkg::REG_COUNT_DEF,
  parameter int RESP_MAX_BYTES = mrtu_pkg::RESP_MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  input  logic [2:0]  in_mode_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic [1:0]  out_queued_mode,
  output logic [15:0] out_acked_mode,
  output logic        out_mode_coil_set,
  output logic [15:0] out_mode_reg_value,
  output logic [31:0] out_coil_reads,
  output logic [31:0] out_holding_reads,
  output logic [31:0] out_input_reads,
  output logic [31:0] out_broadcast_acks,
  output logic [31:0] out_crc_errors
);
  import mrtu_pkg::*;

  localparam int ROWS = (COIL_COUNT + 7) / 8;
  localparam int CAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int HAW  = $clog2(REG_COUNT);
  localparam int BW   = $clog2(RESP_MAX_BYTES + 1);

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_CMD_RD = 17'b00000000000000010,
    S_CMD_WR = 17'b00000000000000100,
    S_SCAN   = 17'b00000000000001000,
    S_CRC    = 17'b00000000000010000,
    S_CHK    = 17'b00000000000100000,
    S_BC_RD  = 17'b00000000001000000,
    S_BC_WR  = 17'b00000000010000000,
    S_STAT   = 17'b00000000100000000,
    S_STAT2  = 17'b00000001000000000,
    S_EMIT   = 17'b00000010000000000,
    S_C1     = 17'b00000100000000000,
    S_C2     = 17'b00001000000000000,
    S_C3     = 17'b00010000000000000,
    S_HRD    = 17'b00100000000000000,
    S_HCAP   = 17'b01000000000000000,
    S_FINAL  = 17'b10000000000000000
  } state_t;

  typedef enum logic [1:0] {
    K_COIL  = 2'd0,
    K_HOLD  = 2'd1,
    K_INPUT = 2'd2,
    K_NONE  = 2'd3
  } resp_kind_t;

  state_t     state_r, state_nxt;
  logic [7:0] buf_r [REQ_LEN];
  logic [7:0] buf_nxt [REQ_LEN];
  logic [3:0] n_r, n_nxt;
  logic [7:0] slave_r, slave_nxt;
  logic [5:0] midx_r, midx_nxt;
  logic [1:0] pend_r, pend_nxt;
  logic [15:0] acked_r, acked_nxt;
  logic [31:0] cnt_coil_r, cnt_coil_nxt, cnt_hold_r, cnt_hold_nxt;
  logic [31:0] cnt_inp_r, cnt_inp_nxt, cnt_bc_r, cnt_bc_nxt, cnt_crc_r, cnt_crc_nxt;
  logic        resp_r, resp_nxt;
  resp_kind_t  kind_r, kind_nxt;
  logic [15:0] start_r, start_nxt, qty_r, qty_nxt;
  logic [BW-1:0] body_r, body_nxt, bi_r, bi_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  crc_idx_r, crc_idx_nxt;
  logic        fetched_r, fetched_nxt;
  logic [7:0]  fbyte_r, fbyte_nxt, lo_r, lo_nxt;
  logic [13:0] row_r, row_nxt;
  logic        rinr_r, rinr_nxt;
  logic [15:0] word_r, word_nxt;
  logic        mcoil_r, mcoil_nxt;
  logic [15:0] mreg_r, mreg_nxt;

  logic        ov_r, ov_nxt;
  logic        otv_r, otv_nxt;
  logic [7:0]  otb_r, otb_nxt;
  logic        otl_r, otl_nxt;
  logic [1:0]  opm_r, opm_nxt;
  logic [15:0] oack_r, oack_nxt;
  logic        omc_r, omc_nxt;
  logic [15:0] omr_r, omr_nxt;
  logic [31:0] oc0_r, oc0_nxt, oc1_r, oc1_nxt, oc2_r, oc2_nxt, oc3_r, oc3_nxt, oc4_r, oc4_nxt;

  logic           coil_rd, coil_wr;
  logic [CAW-1:0] coil_addr;
  logic [7:0]     coil_wdata, coil_rdata;
  logic           hold_rd, hold_wr;
  logic [HAW-1:0] hold_addr;
  logic [15:0]    hold_wdata, hold_rdata;

  logic        is_bc, is_ours, anchor;
  logic [15:0] fp, fq;
  logic [13:0] bc_cnt;
  logic        coil_ok, hold_ok, input_ok;
  logic        mi_in_coil, mi_in_reg, st_in_coil, st_in_reg;
  logic [BW-1:0] dj;
  logic        in_data, last_byte, need_fetch, slot_free, load;
  logic [16:0] coil_s;
  logic [13:0] coil_row, row_p1;
  logic        row_in, row_p1_in;
  logic [HAW-1:0] hold_ra;
  logic [15:0] inp_val;
  logic [7:0]  emit_byte, fc_code, hi_row;
  logic [15:0] comb16;
  logic [7:0]  cbyte;

  mrtu_coil_mem #(.ROWS(ROWS), .AW(CAW)) u_coil (
    .clk(clk), .rst_n(rst_n), .rd_en(coil_rd), .wr_en(coil_wr),
    .addr(coil_addr), .wdata(coil_wdata), .rdata(coil_rdata)
  );

  mrtu_hold_mem #(.DEPTH(REG_COUNT), .AW(HAW)) u_hold (
    .clk(clk), .rst_n(rst_n), .rd_en(hold_rd), .wr_en(hold_wr),
    .addr(hold_addr), .wdata(hold_wdata), .rdata(hold_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !ov_r || out_ready;

  always_comb begin
    is_bc   = (buf_r[0] == 8'h00) && (buf_r[1] == FC_BCAST);
    is_ours = (buf_r[0] == slave_r) &&
              ((buf_r[1] == FC_COILS) || (buf_r[1] == FC_HOLD) || (buf_r[1] == FC_INPUT));
    anchor  = is_bc || is_ours;
    fp      = {buf_r[2], buf_r[3]};
    fq      = {buf_r[4], buf_r[5]};
    bc_cnt  = 14'((17'(fq) + 17'd7) >> 3);
    coil_ok = (fq != 16'd0) && (32'(fq) <= COIL_QTY_MAX) &&
              (32'(bc_cnt) + 32'd5 <= 32'(RESP_MAX_BYTES));
    hold_ok = (fq != 16'd0) && (32'(fq) <= HOLD_QTY_MAX) &&
              (32'(fp) + 32'(fq) <= 32'(REG_COUNT));
    input_ok = (fq != 16'd0) && (32'(fq) <= INPUT_REG_NUM) &&
               (32'(fp) + 32'(fq) <= INPUT_REG_NUM);
    mi_in_coil = 32'(midx_r) < 32'(COIL_COUNT);
    mi_in_reg  = 32'(midx_r) < 32'(REG_COUNT);
    st_in_coil = 32'(start_r) < 32'(COIL_COUNT);
    st_in_reg  = 32'(start_r) < 32'(REG_COUNT);

    dj        = bi_r - BW'(3);
    in_data   = (bi_r >= BW'(3)) && (bi_r < body_r);
    last_byte = (bi_r == body_r + BW'(1));
    coil_s    = 17'(start_r) + (17'(dj) << 3);
    coil_row  = coil_s[16:3];
    row_in    = 32'(coil_row) < 32'(ROWS);
    row_p1    = row_r + 14'd1;
    row_p1_in = 32'(row_p1) < 32'(ROWS);
    hold_ra   = HAW'(32'(start_r) + 32'(dj >> 1));
    inp_val   = input_reg(2'(start_r + 16'(dj >> 1)));
    need_fetch = in_data && !fetched_r &&
                 ((kind_r == K_COIL) || ((kind_r == K_HOLD) && !dj[0]));

    unique case (kind_r)
      K_COIL:  fc_code = FC_COILS;
      K_HOLD:  fc_code = FC_HOLD;
      K_INPUT: fc_code = FC_INPUT;
      default: fc_code = 8'h00;
    endcase

    priority if (bi_r == BW'(0)) begin
      emit_byte = slave_r;
    end else if (bi_r == BW'(1)) begin
      emit_byte = fc_code;
    end else if (bi_r == BW'(2)) begin
      emit_byte = 8'(body_r - BW'(3));
    end else if (in_data) begin
      unique case (kind_r)
        K_COIL:  emit_byte = fbyte_r;
        K_HOLD:  emit_byte = dj[0] ? word_r[7:0] : word_r[15:8];
        K_INPUT: emit_byte = dj[0] ? inp_val[7:0] : inp_val[15:8];
        default: emit_byte = 8'h00;
      endcase
    end else if (bi_r == body_r) begin
      emit_byte = crc_r[7:0];
    end else begin
      emit_byte = crc_r[15:8];
    end

    hi_row = rinr_r ? coil_rdata : 8'h00;
    comb16 = {hi_row, lo_r} >> start_r[2:0];
    for (int k = 0; k < 8; k++) begin
      cbyte[k] = comb16[k] && ((32'(dj) << 3) + 32'(k) < 32'(qty_r));
    end
  end

  always_comb begin
    state_nxt   = state_r;
    buf_nxt     = buf_r;
    n_nxt       = n_r;
    slave_nxt   = slave_r;
    midx_nxt    = midx_r;
    pend_nxt    = pend_r;
    acked_nxt   = acked_r;
    cnt_coil_nxt = cnt_coil_r;
    cnt_hold_nxt = cnt_hold_r;
    cnt_inp_nxt = cnt_inp_r;
    cnt_bc_nxt  = cnt_bc_r;
    cnt_crc_nxt = cnt_crc_r;
    resp_nxt    = resp_r;
    kind_nxt    = kind_r;
    start_nxt   = start_r;
    qty_nxt     = qty_r;
    body_nxt    = body_r;
    bi_nxt      = bi_r;
    crc_nxt     = crc_r;
    crc_idx_nxt = crc_idx_r;
    fetched_nxt = fetched_r;
    fbyte_nxt   = fbyte_r;
    lo_nxt      = lo_r;
    row_nxt     = row_r;
    rinr_nxt    = rinr_r;
    word_nxt    = word_r;
    mcoil_nxt   = mcoil_r;
    mreg_nxt    = mreg_r;
    load        = 1'b0;
    otv_nxt     = 1'b0;
    otb_nxt     = 8'h00;
    otl_nxt     = 1'b1;

    coil_rd    = 1'b0;
    coil_wr    = 1'b0;
    coil_addr  = '0;
    coil_wdata = 8'h00;
    hold_rd    = 1'b0;
    hold_wr    = 1'b0;
    hold_addr  = '0;
    hold_wdata = 16'h0000;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDR: slave_nxt = cfg_data;
        CFG_MODE_INDEX: midx_nxt  = cfg_data[5:0];
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          resp_nxt = 1'b0;
          if (in_cmd) begin
            if (in_mode_value <= 3'd3) begin
              pend_nxt  = in_mode_value[1:0];
              state_nxt = S_CMD_RD;
            end else begin
              state_nxt = S_STAT;
            end
          end else begin
            buf_nxt[n_r[2:0]] = in_rx_byte;
            n_nxt     = n_r + 4'd1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_CMD_RD: begin
        coil_rd   = mi_in_coil;
        coil_addr = CAW'(midx_r >> 3);
        state_nxt = S_CMD_WR;
      end
      S_CMD_WR: begin
        coil_wr    = mi_in_coil;
        coil_addr  = CAW'(midx_r >> 3);
        coil_wdata = coil_rdata | (8'd1 << midx_r[2:0]);
        hold_wr    = mi_in_reg;
        hold_addr  = HAW'(midx_r);
        hold_wdata = {14'd0, pend_r};
        state_nxt  = S_STAT;
      end
      S_SCAN: begin
        if (n_r < 4'd2) begin
          state_nxt = S_STAT;
        end else if (anchor) begin
          if (n_r < 4'(REQ_LEN)) begin
            state_nxt = S_STAT;
          end else begin
            crc_nxt     = 16'hFFFF;
            crc_idx_nxt = 3'd0;
            state_nxt   = S_CRC;
          end
        end else begin
          for (int i = 0; i < REQ_LEN - 1; i++) buf_nxt[i] = buf_r[i+1];
          n_nxt = n_r - 4'd1;
        end
      end
      S_CRC: begin
        crc_nxt = crc_byte(crc_r, buf_r[crc_idx_r]);
        if (crc_idx_r == 3'd5) begin
          state_nxt = S_CHK;
        end else begin
          crc_idx_nxt = crc_idx_r + 3'd1;
        end
      end
      S_CHK: begin
        if (crc_r == {buf_r[7], buf_r[6]}) begin
          n_nxt     = 4'd0;
          start_nxt = fp;
          qty_nxt   = fq;
          crc_nxt   = 16'hFFFF;
          bi_nxt    = '0;
          fetched_nxt = 1'b0;
          state_nxt = S_STAT;
          if (is_bc) begin
            cnt_bc_nxt = cnt_bc_r + 32'd1;
            state_nxt  = S_BC_RD;
          end else if (buf_r[1] == FC_COILS) begin
            kind_nxt = K_COIL;
            if (coil_ok) begin
              resp_nxt     = 1'b1;
              body_nxt     = BW'(32'd3 + 32'(bc_cnt));
              cnt_coil_nxt = cnt_coil_r + 32'd1;
            end
          end else if (buf_r[1] == FC_HOLD) begin
            kind_nxt = K_HOLD;
            if (hold_ok) begin
              resp_nxt     = 1'b1;
              body_nxt     = BW'(32'd3 + 2 * 32'(fq));
              cnt_hold_nxt = cnt_hold_r + 32'd1;
            end
          end else begin
            kind_nxt = K_INPUT;
            if (input_ok) begin
              resp_nxt    = 1'b1;
              body_nxt    = BW'(32'd3 + 2 * 32'(fq));
              cnt_inp_nxt = cnt_inp_r + 32'd1;
            end
          end
        end else begin
          cnt_crc_nxt = cnt_crc_r + 32'd1;
          for (int i = 0; i < REQ_LEN - 1; i++) buf_nxt[i] = buf_r[i+1];
          n_nxt     = n_r - 4'd1;
          state_nxt = S_SCAN;
        end
      end
      S_BC_RD: begin
        coil_rd   = st_in_coil && st_in_reg;
        coil_addr = CAW'(start_r >> 3);
        state_nxt = S_BC_WR;
      end
      S_BC_WR: begin
        if (st_in_reg) begin
          hold_wr    = 1'b1;
          hold_addr  = HAW'(start_r);
          hold_wdata = qty_r;
          coil_wr    = st_in_coil;
          coil_addr  = CAW'(start_r >> 3);
          coil_wdata = coil_rdata & ~(8'd1 << start_r[2:0]);
          if (start_r == 16'(midx_r)) acked_nxt = qty_r;
        end
        state_nxt = S_STAT;
      end
      S_STAT: begin
        coil_rd   = mi_in_coil;
        coil_addr = CAW'(midx_r >> 3);
        hold_rd   = mi_in_reg;
        hold_addr = HAW'(midx_r);
        state_nxt = S_STAT2;
      end
      S_STAT2: begin
        mcoil_nxt = mi_in_coil ? coil_rdata[midx_r[2:0]] : 1'b0;
        mreg_nxt  = mi_in_reg ? hold_rdata : 16'h0000;
        state_nxt = resp_r ? S_EMIT : S_FINAL;
      end
      S_EMIT: begin
        if (need_fetch) begin
          state_nxt = (kind_r == K_COIL) ? S_C1 : S_HRD;
        end else if (slot_free) begin
          load        = 1'b1;
          otv_nxt     = 1'b1;
          otb_nxt     = emit_byte;
          otl_nxt     = last_byte;
          fetched_nxt = 1'b0;
          bi_nxt      = bi_r + BW'(1);
          if (bi_r < body_r) crc_nxt = crc_byte(crc_r, emit_byte);
          if (last_byte) state_nxt = S_IDLE;
        end
      end
      S_C1: begin
        coil_rd   = row_in;
        coil_addr = CAW'(coil_row);
        row_nxt   = coil_row;
        rinr_nxt  = row_in;
        state_nxt = S_C2;
      end
      S_C2: begin
        lo_nxt    = rinr_r ? coil_rdata : 8'h00;
        coil_rd   = row_p1_in;
        coil_addr = CAW'(row_p1);
        rinr_nxt  = row_p1_in;
        state_nxt = S_C3;
      end
      S_C3: begin
        fbyte_nxt   = cbyte;
        fetched_nxt = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_HRD: begin
        hold_rd   = 1'b1;
        hold_addr = hold_ra;
        state_nxt = S_HCAP;
      end
      S_HCAP: begin
        word_nxt    = hold_rdata;
        fetched_nxt = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_FINAL: begin
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    ov_nxt   = load ? 1'b1 : (ov_r && !out_ready);
    opm_nxt  = load ? pend_r : opm_r;
    oack_nxt = load ? acked_r : oack_r;
    omc_nxt  = load ? mcoil_r : omc_r;
    omr_nxt  = load ? mreg_r : omr_r;
    oc0_nxt  = load ? cnt_coil_r : oc0_r;
    oc1_nxt  = load ? cnt_hold_r : oc1_r;
    oc2_nxt  = load ? cnt_inp_r : oc2_r;
    oc3_nxt  = load ? cnt_bc_r : oc3_r;
    oc4_nxt  = load ? cnt_crc_r : oc4_r;
    if (!load) begin
      otv_nxt = otv_r;
      otb_nxt = otb_r;
      otl_nxt = otl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      n_r        <= 4'd0;
      slave_r    <= SLAVE_RST;
      midx_r     <= 6'(MODE_IDX_RST);
      pend_r     <= BOOT_MODE;
      acked_r    <= NO_ACK;
      cnt_coil_r <= '0;
      cnt_hold_r <= '0;
      cnt_inp_r  <= '0;
      cnt_bc_r   <= '0;
      cnt_crc_r  <= '0;
      resp_r     <= 1'b0;
      fetched_r  <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      n_r        <= n_nxt;
      slave_r    <= slave_nxt;
      midx_r     <= midx_nxt;
      pend_r     <= pend_nxt;
      acked_r    <= acked_nxt;
      cnt_coil_r <= cnt_coil_nxt;
      cnt_hold_r <= cnt_hold_nxt;
      cnt_inp_r  <= cnt_inp_nxt;
      cnt_bc_r   <= cnt_bc_nxt;
      cnt_crc_r  <= cnt_crc_nxt;
      resp_r     <= resp_nxt;
      fetched_r  <= fetched_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r     <= buf_nxt;
    kind_r    <= kind_nxt;
    start_r   <= start_nxt;
    qty_r     <= qty_nxt;
    body_r    <= body_nxt;
    bi_r      <= bi_nxt;
    crc_r     <= crc_nxt;
    crc_idx_r <= crc_idx_nxt;
    fbyte_r   <= fbyte_nxt;
    lo_r      <= lo_nxt;
    row_r     <= row_nxt;
    rinr_r    <= rinr_nxt;
    word_r    <= word_nxt;
    mcoil_r   <= mcoil_nxt;
    mreg_r    <= mreg_nxt;
    otv_r     <= otv_nxt;
    otb_r     <= otb_nxt;
    otl_r     <= otl_nxt;
    opm_r     <= opm_nxt;
    oack_r    <= oack_nxt;
    omc_r     <= omc_nxt;
    omr_r     <= omr_nxt;
    oc0_r     <= oc0_nxt;
    oc1_r     <= oc1_nxt;
    oc2_r     <= oc2_nxt;
    oc3_r     <= oc3_nxt;
    oc4_r     <= oc4_nxt;
  end

  assign out_valid          = ov_r;
  assign out_tx_valid       = otv_r;
  assign out_tx_byte        = otb_r;
  assign out_tx_last        = otl_r;
  assign out_queued_mode    = opm_r;
  assign out_acked_mode     = oack_r;
  assign out_mode_coil_set  = omc_r;
  assign out_mode_reg_value = omr_r;
  assign out_coil_reads     = oc0_r;
  assign out_holding_reads  = oc1_r;
  assign out_input_reads    = oc2_r;
  assign out_broadcast_acks = oc3_r;
  assign out_crc_errors     = oc4_r;

endmodule

>>> src/mrtu_coil_mem.sv
// ----------------------------------------------------------------------------
// mrtu_coil_mem
// Coil bit store, eight coils per row, one read or write per cycle.
// ----------------------------------------------------------------------------
module mrtu_coil_mem #(
  parameter int ROWS = 64,
  parameter int AW   = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic          wr_en,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);
  import mrtu_pkg::*;

  localparam logic [AW-1:0] RST_ROW  = AW'(MODE_IDX_RST / 8);
  localparam logic [7:0]    RST_BITS = 8'(1 << (MODE_IDX_RST % 8));

  logic [7:0]      mem_r [ROWS];
  logic [ROWS-1:0] vld_r;
  logic [7:0]      rdat_r;
  logic            rvld_r;
  logic            rrst_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wdata;
    end
    if (rd_en) begin
      rdat_r <= mem_r[addr];
      rvld_r <= vld_r[addr];
      rrst_r <= (addr == RST_ROW);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[addr] <= 1'b1;
    end
  end

  assign rdata = rvld_r ? rdat_r : (rrst_r ? RST_BITS : 8'h00);

endmodule

>>> src/mrtu_hold_mem.sv
// ----------------------------------------------------------------------------
// mrtu_hold_mem
// Holding register store, one read or write per cycle.
// ----------------------------------------------------------------------------
module mrtu_hold_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic          wr_en,
  input  logic [AW-1:0] addr,
  input  logic [15:0]   wdata,
  output logic [15:0]   rdata
);
  import mrtu_pkg::*;

  localparam logic [AW-1:0] RST_IDX = AW'(MODE_IDX_RST);

  logic [15:0]      mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [15:0]      rdat_r;
  logic             rvld_r;
  logic             rrst_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wdata;
    end
    if (rd_en) begin
      rdat_r <= mem_r[addr];
      rvld_r <= vld_r[addr];
      rrst_r <= (addr == RST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[addr] <= 1'b1;
    end
  end

  assign rdata = rvld_r ? rdat_r : (rrst_r ? {14'd0, BOOT_MODE} : 16'h0000);

endmodule

>>> src/mrtu_checker.sv
// ----------------------------------------------------------------------------
// mrtu_checker
// Port-level checks of the frame engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "modbus_rtu_slave_frame_engine_assert.svh"

module mrtu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_byte,
  input logic       out_tx_last
);

  `MRTU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_tx_byte))
  `MRTU_ASSERT_NOW(a_status_only, out_valid && !out_tx_valid, out_tx_last && out_tx_byte == 8'h00)
  `MRTU_ASSERT_NOW(a_accept_after_last, in_valid && in_ready, !out_valid || out_tx_last)

endmodule

bind modbus_rtu_slave_frame_engine mrtu_checker u_mrtu_checker (.*);

>>> verif/tb_modbus_rtu_slave_frame_engine.sv
// ----------------------------------------------------------------------------
// Modbus RTU slave frame engine testbench
// Drives received bytes and host mode commands, predicts response frames and
// status per transfer, and compares every result against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_modbus_rtu_slave_frame_engine;
  import mrtu_pkg::*;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [1:0]  queued_mode;
    logic [15:0] acked_mode;
    logic        mode_coil_set;
    logic [15:0] mode_reg_value;
    logic [31:0] coil_reads;
    logic [31:0] holding_reads;
    logic [31:0] input_reads;
    logic [31:0] broadcast_acks;
    logic [31:0] crc_errors;
  } slave_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [7:0]  in_rx_byte;
  logic [2:0]  in_mode_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        out_valid;
  logic        out_ready;
  slave_result_t act;

  modbus_rtu_slave_frame_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_rx_byte(in_rx_byte), .in_mode_value(in_mode_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tx_valid(act.tx_valid), .out_tx_byte(act.tx_byte), .out_tx_last(act.tx_last),
    .out_queued_mode(act.queued_mode), .out_acked_mode(act.acked_mode),
    .out_mode_coil_set(act.mode_coil_set), .out_mode_reg_value(act.mode_reg_value),
    .out_coil_reads(act.coil_reads), .out_holding_reads(act.holding_reads),
    .out_input_reads(act.input_reads), .out_broadcast_acks(act.broadcast_acks),
    .out_crc_errors(act.crc_errors)
  );

  // slave model state
  logic [7:0]  m_slave;
  logic [5:0]  m_midx;
  logic [7:0]  m_win [0:6];
  int          m_wcnt;
  logic        m_coil [0:511];
  logic [15:0] m_hold [0:63];
  logic [1:0]  m_pend;
  logic [15:0] m_acked;
  logic [31:0] m_cnt [0:4];
  logic [7:0]  resp [0:71];
  int          rsp_count;

  slave_result_t response_q[$];
  int  mismatches;
  int  idle_pct;
  int  stall_pct;
  int  quiet_cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] modbus_crc(input logic [7:0] d [0:71], input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {8'h00, d[i]};
      for (int k = 0; k < 8; k++) c = (c >> 1) ^ (c[0] ? 16'hA001 : 16'h0000);
    end
    return c;
  endfunction

  task automatic model_reset();
    m_slave = SLAVE_RST;
    m_midx = 6'd0;
    m_wcnt = 0;
    for (int i = 0; i < 512; i++) m_coil[i] = 1'b0;
    for (int i = 0; i < 64; i++) m_hold[i] = 16'h0000;
    m_coil[0] = 1'b1;
    m_hold[0] = 16'(BOOT_MODE);
    m_pend = BOOT_MODE;
    m_acked = NO_ACK;
    for (int i = 0; i < 5; i++) m_cnt[i] = 32'd0;
  endtask

  task automatic stamp(input int body);
    logic [15:0] c;
    c = modbus_crc(resp, body);
    resp[body] = c[7:0];
    resp[body+1] = c[15:8];
    rsp_count = body + 2;
  endtask

  task automatic answer_request(input logic [7:0] fc, input int p, input int q);
    int bc;
    if (fc == FC_COILS) begin
      if (q == 0 || q > COIL_QTY_MAX) return;
      bc = (q + 7) / 8;
      if (5 + bc > 64) return;
      resp[0] = m_slave; resp[1] = FC_COILS; resp[2] = 8'(bc);
      for (int i = 0; i < bc; i++) resp[3+i] = 8'h00;
      for (int i = 0; i < q && p + i < 512; i++)
        if (m_coil[p+i]) resp[3+i/8][i%8] = 1'b1;
      m_cnt[0]++;
      stamp(3 + bc);
    end else begin
      if (q == 0 || q > ((fc == FC_HOLD) ? HOLD_QTY_MAX : INPUT_REG_NUM)) return;
      if (p + q > ((fc == FC_HOLD) ? 64 : INPUT_REG_NUM)) return;
      resp[0] = m_slave; resp[1] = fc; resp[2] = 8'(2 * q);
      for (int i = 0; i < q; i++) begin
        {resp[3+2*i], resp[4+2*i]} = (fc == FC_HOLD) ? m_hold[p+i] :
          (p + i == 2) ? 16'h0001 : (p + i == 3) ? 16'h0200 : 16'h0000;
      end
      m_cnt[(fc == FC_HOLD) ? 1 : 2]++;
      stamp(3 + 2 * q);
    end
  endtask

  task automatic predict_transfer(input logic c, input logic [7:0] rx, input logic [2:0] mv);
    logic [7:0] w [0:71];
    int n;
    int p, q;
    logic ours, bcast;
    slave_result_t r;
    rsp_count = 0;
    if (c) begin
      if (mv <= 3) begin
        m_hold[m_midx] = 16'(mv);
        m_coil[m_midx] = 1'b1;
        m_pend = mv[1:0];
      end
    end else begin
      n = m_wcnt;
      for (int i = 0; i < n; i++) w[i] = m_win[i];
      w[n++] = rx;
      while (n >= 2) begin
        ours = (w[0] == m_slave) && (w[1] == FC_COILS || w[1] == FC_HOLD || w[1] == FC_INPUT);
        bcast = (w[0] == 8'h00) && (w[1] == FC_BCAST);
        if (ours || bcast) begin
          if (n < REQ_LEN) break;
          if (modbus_crc(w, 6) == {w[7], w[6]}) begin
            p = {w[2], w[3]};
            q = {w[4], w[5]};
            if (bcast) begin
              m_cnt[3]++;
              if (p < 64) begin
                m_hold[p] = 16'(q);
                m_coil[p] = 1'b0;
                if (p == m_midx) m_acked = 16'(q);
              end
            end else answer_request(w[1], p, q);
            n = 0;
            break;
          end
          m_cnt[4]++;
        end
        for (int i = 0; i < n - 1; i++) w[i] = w[i+1];
        n--;
      end
      for (int i = 0; i < n; i++) m_win[i] = w[i];
      m_wcnt = n;
    end
    r.queued_mode = m_pend;
    r.acked_mode = m_acked;
    r.mode_coil_set = m_coil[m_midx];
    r.mode_reg_value = m_hold[m_midx];
    r.coil_reads = m_cnt[0];
    r.holding_reads = m_cnt[1];
    r.input_reads = m_cnt[2];
    r.broadcast_acks = m_cnt[3];
    r.crc_errors = m_cnt[4];
    if (rsp_count == 0) begin
      r.tx_valid = 0; r.tx_byte = 0; r.tx_last = 1;
      response_q.push_back(r);
    end else begin
      for (int i = 0; i < rsp_count; i++) begin
        r.tx_valid = 1; r.tx_byte = resp[i]; r.tx_last = (i == rsp_count - 1);
        response_q.push_back(r);
      end
    end
  endtask

  // one input transfer; called and returns on a falling edge
  task automatic send_item(input logic c, input logic [7:0] rx, input logic [2:0] mv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 0;
      in_cmd = 1'($urandom);
      in_rx_byte = 8'($urandom);
      in_mode_value = 3'($urandom);
      @(negedge clk);
    end
    in_valid = 1; in_cmd = c; in_rx_byte = rx; in_mode_value = mv;
    do @(posedge clk); while (!in_ready);
    predict_transfer(c, rx, mv);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic send_frame(input logic [7:0] a, input logic [7:0] fc, input logic [15:0] p,
                            input logic [15:0] q, input logic corrupt);
    logic [7:0] f [0:71];
    logic [15:0] c;
    f[0] = a; f[1] = fc; f[2] = p[15:8]; f[3] = p[7:0]; f[4] = q[15:8]; f[5] = q[7:0];
    c = modbus_crc(f, 6);
    f[6] = c[7:0]; f[7] = c[15:8];
    if (corrupt) f[$urandom_range(2, 7)] ^= 8'(1 << $urandom_range(7));
    for (int i = 0; i < 8; i++) send_item(1'b0, f[i], 3'($urandom));
  endtask

  task automatic drain();
    while (response_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    drain();
    cfg_valid = 1; cfg_index = idx; cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SLAVE_ADDR) m_slave = val;
    else m_midx = val[5:0];
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic test_directed();
    idle_pct = 0; stall_pct = 0;
    send_item(1, 8'hFF, 3'd7);
    send_item(1, 8'h00, 3'd0);
    send_item(1, 8'hA5, 3'd3);
    send_item(0, 8'hFF, 3'd0);
    send_item(0, 8'h00, 3'd0);
    send_frame(m_slave, FC_HOLD, 0, 8, 0);
    send_frame(m_slave, FC_HOLD, 60, 4, 0);
    send_frame(m_slave, FC_HOLD, 61, 4, 0);
    send_frame(m_slave, FC_HOLD, 0, 9, 0);
    send_frame(m_slave, FC_INPUT, 0, 4, 0);
    send_frame(m_slave, FC_INPUT, 1, 4, 0);
    send_frame(m_slave, FC_INPUT, 0, 0, 0);
    send_frame(m_slave, FC_COILS, 0, 1, 0);
    send_frame(m_slave, FC_COILS, 505, 472, 0);
    send_frame(m_slave, FC_COILS, 0, 473, 0);
    send_frame(m_slave, FC_COILS, 0, 2000, 0);
    send_frame(m_slave, FC_COILS, 0, 0, 0);
    send_frame(8'h00, FC_BCAST, 16'(m_midx), 16'h0001, 0);
    send_frame(8'h00, FC_BCAST, 63, 16'hFFFF, 0);
    send_frame(8'h00, FC_BCAST, 16'hFFFF, 16'h1234, 0);
    send_frame(m_slave, FC_HOLD, 0, 2, 1);
    send_frame(8'h00, FC_BCAST, 5, 5, 1);
  endtask

  task automatic test_random(input int items);
    int sent;
    int pick;
    logic [7:0] a;
    logic [7:0] fc;
    logic [15:0] p, q;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_item(1'b1, 8'($urandom), 3'($urandom));
        sent++;
      end else if (pick < 22) begin
        send_item(1'b0, 8'($urandom), 3'($urandom));
        sent++;
      end else begin
        case ($urandom_range(3))
          0: fc = FC_COILS;
          1: fc = FC_HOLD;
          2: fc = FC_INPUT;
          default: fc = FC_BCAST;
        endcase
        a = (fc == FC_BCAST) ? 8'h00 : ($urandom_range(9) == 0) ? 8'($urandom) : m_slave;
        p = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(70));
        if (fc == FC_COILS) q = ($urandom_range(9) == 0) ? 16'($urandom_range(480))
                                                            : 16'($urandom_range(24));
        else if (fc == FC_BCAST) q = ($urandom_range(3) == 0) ? 16'($urandom_range(3))
                                                               : 16'($urandom);
        else q = 16'($urandom_range(9));
        if (fc == FC_BCAST && $urandom_range(3) == 0) p = 16'(m_midx);
        send_frame(a, fc, p, q, $urandom_range(7) == 0);
        sent += 8;
      end
      if ($urandom_range(40) == 0) drain();
    end
  endtask

  task automatic test_config();
    write_reg(CFG_SLAVE_ADDR, 8'd1);
    write_reg(CFG_MODE_INDEX, 8'd63);
    test_random(15);
    write_reg(CFG_SLAVE_ADDR, 8'd247);
    write_reg(CFG_MODE_INDEX, 8'd0);
    test_random(15);
    write_reg(CFG_SLAVE_ADDR, 8'($urandom_range(1, 247)));
    write_reg(CFG_MODE_INDEX, 8'($urandom_range(63)));
    test_random(15);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (response_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", act);
      end else begin
        if (response_q[0] !== act) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", response_q[0], act);
        end
        void'(response_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 40000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0; in_cmd = 0; in_rx_byte = 0; in_mode_value = 0;
    cfg_valid = 0; cfg_index = CFG_SLAVE_ADDR; cfg_data = 0;
    mismatches = 0; quiet_cycles = 0;
    idle_pct = 0; stall_pct = 0;
    model_reset();
    repeat (12) @(negedge clk);
    rst_n = 1;
    test_directed();
    idle_pct = 0;  stall_pct = 0;  test_random(25);
    idle_pct = 72; stall_pct = 0;  test_random(25);
    idle_pct = 0;  stall_pct = 72; test_random(25);
    idle_pct = 28; stall_pct = 28; test_random(25);
    test_config();
    drain();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && response_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
